// ===== rtl/esim_pkg.sv =====
// ============================================================================
// esim_pkg
// Shared widths, codes, types and helpers for the escape symbol interval mapper.
// ============================================================================
package esim_pkg;

    // Table geometry
    localparam int TABLE_W        = 6;
    localparam int ENTRY_W        = 8;
    localparam int NUM_TABLES     = 1 << TABLE_W;
    localparam int MAX_BOUNDARIES = 1 << ENTRY_W;
    localparam int BND_ADDR_W     = TABLE_W + ENTRY_W;
    localparam int BND_DEPTH      = NUM_TABLES * MAX_BOUNDARIES;

    // Field widths
    localparam int CDF_PRECISION  = 16;
    localparam int VAL_W          = CDF_PRECISION;
    localparam int FREQ_W         = CDF_PRECISION + 1;
    localparam int CNT_W          = ENTRY_W + 1;
    localparam int SYM_W          = 16;
    localparam int DIFF_W         = SYM_W + 1;
    localparam int SCALE_W        = 5;
    localparam int ACT_W          = 2;

    // Packed bus widths
    localparam int IN_DATA_W      = 72;
    localparam int OUT_DATA_W     = 40;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_LOAD_BOUND  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD_HEADER = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ENCODE      = 2'd2;

    localparam logic [FREQ_W-1:0]  FULL_SCALE = FREQ_W'(1) << CDF_PRECISION;
    localparam logic [SCALE_W-1:0] SCALE_BIT  = SCALE_W'(1);
    localparam logic [SCALE_W-1:0] SCALE_CDF  = SCALE_W'(CDF_PRECISION);

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [SYM_W-1:0] off;
    } t_hdr;

    // Work handed from the pipeline to the escape sequencer
    typedef struct packed {
        logic              esc;
        logic              neg;
        logic [DIFF_W-1:0] mag;
        logic [VAL_W-1:0]  start;
        logic [FREQ_W-1:0] freq;
        logic              err;
    } t_job;

    typedef struct packed {
        logic               last;
        logic               err;
        logic [SCALE_W-1:0] scale;
        logic [FREQ_W-1:0]  freq;
        logic [VAL_W-1:0]   start;
    } t_result;

    function automatic t_result mk_bit(input logic b);
        t_result r;
        r.last  = 1'b0;
        r.err   = 1'b0;
        r.scale = SCALE_BIT;
        r.freq  = FREQ_W'(1);
        r.start = VAL_W'(b);
        return r;
    endfunction

    function automatic t_result mk_final(input logic [VAL_W-1:0] start,
                                         input logic [FREQ_W-1:0] freq,
                                         input logic err);
        t_result r;
        r.last  = 1'b1;
        r.err   = err;
        r.scale = SCALE_CDF;
        r.freq  = freq;
        r.start = start;
        return r;
    endfunction

endpackage

// ===== rtl/esim_seq.sv =====
// ============================================================================
// esim_seq
// Escape sequencer: expands one job into sign, exp-Golomb and final intervals.
// ============================================================================
module esim_seq
    import esim_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_job_valid,
    input  t_job    i_job,
    output logic    o_job_ready,
    output logic    o_out_valid,
    output t_result o_out,
    input  logic    i_out_ready
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_BITS  = 2'd1;
    localparam logic [1:0] ST_ZEROS = 2'd2;
    localparam logic [1:0] ST_FINAL = 2'd3;

    localparam int ZC_W = $clog2(DIFF_W + 1);

    logic [1:0]        r_state, n_state;
    logic [DIFF_W-1:0] r_mag, n_mag;
    logic [ZC_W-1:0]   r_zcnt, n_zcnt;
    t_result           r_fin, n_fin;
    t_result           r_out, n_out;
    logic              r_out_valid, n_out_valid;
    logic              out_free;
    logic              load_out;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_mag       = r_mag;
        n_zcnt      = r_zcnt;
        n_fin       = r_fin;
        n_out       = r_out;
        load_out    = 1'b0;
        o_job_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_job_ready = out_free;
                if (out_free && i_job_valid) begin
                    load_out = 1'b1;
                    if (i_job.esc) begin
                        n_out   = mk_bit(i_job.neg);
                        n_mag   = i_job.mag;
                        n_zcnt  = '0;
                        n_fin   = mk_final(i_job.start, i_job.freq, i_job.err);
                        n_state = ST_BITS;
                    end else begin
                        n_out = mk_final(i_job.start, i_job.freq, i_job.err);
                    end
                end
            end
            ST_BITS: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_out    = mk_bit(r_mag[0]);
                    n_mag    = r_mag >> 1;
                    // zcnt ends as (bit length - 1), the zero run that follows
                    if (r_mag[DIFF_W-1:1] == '0) begin
                        n_state = (r_zcnt == '0) ? ST_FINAL : ST_ZEROS;
                    end else begin
                        n_zcnt = r_zcnt + ZC_W'(1);
                    end
                end
            end
            ST_ZEROS: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_out    = mk_bit(1'b0);
                    n_zcnt   = r_zcnt - ZC_W'(1);
                    if (r_zcnt == ZC_W'(1)) begin
                        n_state = ST_FINAL;
                    end
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_out    = r_fin;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_out_valid = load_out || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_mag  <= n_mag;
        r_zcnt <= n_zcnt;
        r_fin  <= n_fin;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== rtl/escape_symbol_interval_mapper.sv =====
// ============================================================================
// escape_symbol_interval_mapper
// Modelling front end of an rANS encoder: maps symbols to CDF intervals,
// escaping out-of-range values with a sign bit and exp-Golomb bits.
// ============================================================================
//
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tuser: action; tdata: table,
//           |     |                              | entry, value, count, offset,
//           |     |                              | symbol
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata: start, freq, scale;
//           |     |                              | tuser: zero-freq error;
//           |     |                              | tlast: last of symbol
//
//  Four register stages (input/header read, offset subtract, range check and
//  boundary read, interval compute) run into the escape sequencer, whose output
//  register is the last. An in-range symbol yields one result; an escaped
//  symbol whose magnitude has L bits yields 2L+1 (sign, L bits, L-1 zeros,
//  final) and holds the sequencer until its final result is issued. Reset
//  (synchronous, active low) clears valids, sequencer state and the header
//  valid bits; boundary words are not cleared. Back-pressure ripples up stage
//  by stage; bubbles collapse, nothing is dropped or repeated.
//
module escape_symbol_interval_mapper
    import esim_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [5:0] table_id, [13:6] entry_index, [29:14] entry_value,
    // [38:30] num_bounds, [54:39] table_offset, [70:55] symbol, [71] pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] action
    input  logic [ACT_W-1:0]      s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [15:0] interval_start, [32:16] interval_frequency, [37:33] scale_bits,
    // [39:38] pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // [0] zero_frequency_error
    output logic                  m_axis_tuser,
    // last_of_symbol
    output logic                  m_axis_tlast
);

    // ---------------- input unpack ----------------
    logic [TABLE_W-1:0] in_table;
    logic [ENTRY_W-1:0] in_entry;
    logic [VAL_W-1:0]   in_value;
    logic [CNT_W-1:0]   in_count;
    logic [SYM_W-1:0]   in_offset;
    logic [SYM_W-1:0]   in_symbol;
    logic               in_accept;

    assign in_table  = s_axis_tdata[5:0];
    assign in_entry  = s_axis_tdata[13:6];
    assign in_value  = s_axis_tdata[29:14];
    assign in_count  = s_axis_tdata[38:30];
    assign in_offset = s_axis_tdata[54:39];
    assign in_symbol = s_axis_tdata[70:55];
    assign in_accept = s_axis_tvalid && s_axis_tready;

    // ---------------- stall chain ----------------
    logic job_ready;
    logic rdy1, rdy2, rdy3;
    logic r_s1_valid, r_s2_valid, r_s3_valid;

    assign rdy3          = !r_s3_valid || job_ready;
    assign rdy2          = !r_s2_valid || rdy3;
    assign rdy1          = !r_s1_valid || rdy2;
    assign s_axis_tready = rdy1;

    // ---------------- header memory (count, offset) ----------------
    // Read and written at the accept edge, so items see headers in order.
    t_hdr              r_hdr_mem [NUM_TABLES];
    logic [NUM_TABLES-1:0] r_hdr_vld;
    t_hdr              hdr_wr;

    always_comb begin
        // counts above the table size saturate
        hdr_wr.cnt = (in_count > CNT_W'(MAX_BOUNDARIES)) ? CNT_W'(MAX_BOUNDARIES)
                                                          : in_count;
        hdr_wr.off = in_offset;
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && s_axis_tuser == ACT_LOAD_HEADER) begin
            r_hdr_mem[in_table] <= hdr_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_vld <= '0;
        end else if (in_accept && s_axis_tuser == ACT_LOAD_HEADER) begin
            r_hdr_vld[in_table] <= 1'b1;
        end
    end

    // ---------------- stage 1: input + header read ----------------
    logic [ACT_W-1:0]   r_s1_action;
    logic [TABLE_W-1:0] r_s1_table;
    logic [ENTRY_W-1:0] r_s1_entry;
    logic [VAL_W-1:0]   r_s1_value;
    logic [SYM_W-1:0]   r_s1_symbol;
    t_hdr               r_s1_hdr;
    logic               r_s1_hvld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (rdy1) begin
            r_s1_valid <= s_axis_tvalid;
        end
        if (in_accept) begin
            r_s1_action <= s_axis_tuser;
            r_s1_table  <= in_table;
            r_s1_entry  <= in_entry;
            r_s1_value  <= in_value;
            r_s1_symbol <= in_symbol;
            r_s1_hdr    <= r_hdr_mem[in_table];
            r_s1_hvld   <= r_hdr_vld[in_table];
        end
    end

    // never-loaded tables read as count 0, offset 0
    logic [CNT_W-1:0]  s1_cnt;
    logic [SYM_W-1:0]  s1_off;
    logic [DIFF_W-1:0] s1_diff;

    assign s1_cnt  = r_s1_hvld ? r_s1_hdr.cnt : '0;
    assign s1_off  = r_s1_hvld ? r_s1_hdr.off : '0;
    assign s1_diff = {r_s1_symbol[SYM_W-1], r_s1_symbol} - {s1_off[SYM_W-1], s1_off};

    // ---------------- stage 2: difference ----------------
    logic [ACT_W-1:0]   r_s2_action;
    logic [TABLE_W-1:0] r_s2_table;
    logic [ENTRY_W-1:0] r_s2_entry;
    logic [VAL_W-1:0]   r_s2_value;
    logic [DIFF_W-1:0]  r_s2_diff;
    logic [CNT_W-1:0]   r_s2_cnt;
    logic               adv1;

    assign adv1 = r_s1_valid && rdy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (rdy2) begin
            r_s2_valid <= r_s1_valid;
        end
        if (adv1) begin
            r_s2_action <= r_s1_action;
            r_s2_table  <= r_s1_table;
            r_s2_entry  <= r_s1_entry;
            r_s2_value  <= r_s1_value;
            r_s2_diff   <= s1_diff;
            r_s2_cnt    <= s1_cnt;
        end
    end

    // range check: negative, or at/above the count, is escaped
    logic              s2_neg;
    logic              s2_esc;
    logic [DIFF_W-1:0] s2_mag;
    logic [CNT_W-1:0]  s2_idx;
    logic [CNT_W-1:0]  s2_idx_m1;
    logic [BND_ADDR_W-1:0] s2_addr_hi, s2_addr_lo;

    always_comb begin
        s2_neg    = r_s2_diff[DIFF_W-1];
        s2_esc    = s2_neg || (r_s2_diff[SYM_W-1:0] >= SYM_W'(r_s2_cnt));
        s2_mag    = s2_neg ? (DIFF_W'(0) - r_s2_diff)
                           : (r_s2_diff - DIFF_W'(r_s2_cnt) + DIFF_W'(1));
        s2_idx    = s2_esc ? r_s2_cnt : r_s2_diff[CNT_W-1:0];
        s2_idx_m1 = s2_idx - CNT_W'(1);
        s2_addr_hi = {r_s2_table, s2_idx[ENTRY_W-1:0]};
        s2_addr_lo = {r_s2_table, s2_idx_m1[ENTRY_W-1:0]};
    end

    // ---------------- boundary memory ----------------
    // Written and read in stage 2 so loads and encodes keep item order.
    // Every 8-bit entry index lies inside the table, so all loads land.
    logic [VAL_W-1:0] r_bnd_mem [BND_DEPTH];
    logic             adv2;

    assign adv2 = r_s2_valid && rdy3;

    always_ff @(posedge i_clk) begin
        if (adv2 && r_s2_action == ACT_LOAD_BOUND) begin
            r_bnd_mem[{r_s2_table, r_s2_entry}] <= r_s2_value;
        end
    end

    // ---------------- stage 3: boundary words ----------------
    logic [VAL_W-1:0]  r_s3_lo, r_s3_hi;
    logic              r_s3_idx_zero;
    logic              r_s3_esc;
    logic              r_s3_neg;
    logic [DIFF_W-1:0] r_s3_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (rdy3) begin
            // only encode items produce results
            r_s3_valid <= r_s2_valid && (r_s2_action == ACT_ENCODE);
        end
        if (adv2) begin
            r_s3_lo       <= r_bnd_mem[s2_addr_lo];
            r_s3_hi       <= r_bnd_mem[s2_addr_hi];
            r_s3_idx_zero <= (s2_idx == '0);
            r_s3_esc      <= s2_esc;
            r_s3_neg      <= s2_neg;
            r_s3_mag      <= s2_mag;
        end
    end

    // interval: escape index ends at full scale; index 0 starts at 0
    logic [FREQ_W-1:0] s3_start, s3_end;
    t_job              job;

    always_comb begin
        s3_start  = r_s3_idx_zero ? '0 : {1'b0, r_s3_lo};
        s3_end    = r_s3_esc ? FULL_SCALE : {1'b0, r_s3_hi};
        job.esc   = r_s3_esc;
        job.neg   = r_s3_neg;
        job.mag   = r_s3_mag;
        job.start = s3_start[VAL_W-1:0];
        if (s3_end > s3_start) begin
            job.freq = s3_end - s3_start;
            job.err  = 1'b0;
        end else begin
            job.freq = '0;
            job.err  = 1'b1;
        end
    end

    // ---------------- escape sequencer + output register ----------------
    t_result out_res;

    esim_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (r_s3_valid),
        .i_job       (job),
        .o_job_ready (job_ready),
        .o_out_valid (m_axis_tvalid),
        .o_out       (out_res),
        .i_out_ready (m_axis_tready)
    );

    assign m_axis_tdata = {2'b00, out_res.scale, out_res.freq, out_res.start};
    assign m_axis_tuser = out_res.err;
    assign m_axis_tlast = out_res.last;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for escape_symbol_interval_mapper. Table headers and
// boundary words are loaded, then symbols are encoded, both in directed form
// and in random sessions, with random idling on both streams. A behavioral
// predictor queues the expected intervals and a checker compares each output
// item field by field.
// ============================================================================
module tb_top;
    import esim_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;  // spare action code, must be dropped

    localparam int RANDOM_ENCODES = 120;   // encodes sent in the random phase
    localparam int STEADY_SESSIONS = 2;    // sessions in the final phase, no idling
    localparam int TAIL_CYCLES    = 16;    // pipeline is four registers deep, give it margin
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any handshake

    // One input item, unpacked. Fields that the action does not use still
    // carry random data so that every input bit is exercised.
    typedef struct {
        logic [ACT_W-1:0]   action;
        logic [TABLE_W-1:0] tbl_idx;
        logic [ENTRY_W-1:0] entry;
        logic [VAL_W-1:0]   value;
        logic [CNT_W-1:0]   count;
        logic [SYM_W-1:0]   offset;
        logic [SYM_W-1:0]   symbol;
    } t_coder_item;

    // ------------------------------------------------------------------------
    // DUT interface
    // ------------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // [5:0] table_id, [13:6] entry_index, [29:14] entry_value,
    // [38:30] num_bounds, [54:39] table_offset, [70:55] symbol, [71] pad
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    // [1:0] action
    logic [ACT_W-1:0]      s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [15:0] interval_start, [32:16] interval_frequency, [37:33] scale_bits,
    // [39:38] pad
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // [0] zero_frequency_error
    logic                  m_axis_tuser;
    // last_of_symbol
    logic                  m_axis_tlast;

    escape_symbol_interval_mapper u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: own copy of the tables. cdf_written tracks which
    // boundary words were loaded, so encodes never touch an unloaded word.
    // ------------------------------------------------------------------------
    bit [VAL_W-1:0] cdf_words   [BND_DEPTH];
    bit             cdf_written [BND_DEPTH];
    int             tbl_count   [NUM_TABLES];
    bit [SYM_W-1:0] tbl_offset  [NUM_TABLES];

    t_result pending_intervals[$];   // expected output items, oldest first

    bit idle_enable   = 1'b1;        // random idling on both streams
    int mismatch_count = 0;
    int encodes_sent   = 0;
    int quiet_cycles   = 0;
    int ready_hold     = 0;

    task automatic report_mismatch(input string what, input logic [39:0] got,
                                   input logic [39:0] want);
        mismatch_count++;
        $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
    endtask

    function automatic void push_interval(input logic [VAL_W-1:0] start,
                                          input logic [FREQ_W-1:0] freq,
                                          input logic [SCALE_W-1:0] scale,
                                          input logic err, input logic last);
        t_result r;
        r.start = start;
        r.freq  = freq;
        r.scale = scale;
        r.err   = err;
        r.last  = last;
        pending_intervals.push_back(r);
    endfunction

    // Applies one accepted item to the table copy; an encode queues its
    // intervals in the order the coder gets them.
    function automatic void predict_intervals(input t_coder_item it);
        int t;
        int n;
        int diff;
        int mag;
        int nbits;
        int idx;
        logic [FREQ_W-1:0] lo;
        logic [FREQ_W-1:0] hi;
        t = int'(it.tbl_idx);
        case (it.action)
            ACT_LOAD_BOUND: begin
                cdf_words[t * MAX_BOUNDARIES + int'(it.entry)]   = it.value;
                cdf_written[t * MAX_BOUNDARIES + int'(it.entry)] = 1'b1;
            end
            ACT_LOAD_HEADER: begin
                // counts above the table depth saturate
                tbl_count[t]  = (int'(it.count) > MAX_BOUNDARIES) ? MAX_BOUNDARIES
                                                                  : int'(it.count);
                tbl_offset[t] = it.offset;
            end
            ACT_ENCODE: begin
                n    = tbl_count[t];
                diff = int'($signed(it.symbol)) - int'($signed(tbl_offset[t]));
                if (diff < 0 || diff >= n) begin
                    // escape: sign, magnitude LSB first, zero padding, then index n
                    mag = (diff < 0) ? -diff : diff - n + 1;
                    push_interval(VAL_W'(diff < 0), FREQ_W'(1), SCALE_BIT, 1'b0, 1'b0);
                    nbits = 0;
                    while (mag != 0) begin
                        push_interval(VAL_W'(mag & 1), FREQ_W'(1), SCALE_BIT, 1'b0, 1'b0);
                        mag = mag >> 1;
                        nbits++;
                    end
                    for (int i = 1; i < nbits; i++)
                        push_interval('0, FREQ_W'(1), SCALE_BIT, 1'b0, 1'b0);
                    idx = n;
                end else begin
                    idx = diff;
                end
                lo = (idx == 0) ? '0 : FREQ_W'(cdf_words[t * MAX_BOUNDARIES + idx - 1]);
                hi = (idx == n) ? FULL_SCALE : FREQ_W'(cdf_words[t * MAX_BOUNDARIES + idx]);
                // an empty or reversed interval is flagged but still sent
                if (hi > lo)
                    push_interval(lo[VAL_W-1:0], hi - lo, SCALE_CDF, 1'b0, 1'b1);
                else
                    push_interval(lo[VAL_W-1:0], '0, SCALE_CDF, 1'b1, 1'b1);
            end
            default: ;   // spare code: no state change, no output
        endcase
    endfunction

    // True when every boundary word the table's count can reach was loaded.
    function automatic bit table_ready(input int t);
        for (int e = 0; e < tbl_count[t]; e++)
            if (!cdf_written[t * MAX_BOUNDARIES + e])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic t_coder_item rand_item(input logic [ACT_W-1:0] act);
        t_coder_item it;
        it.action  = act;
        it.tbl_idx = TABLE_W'($urandom);
        it.entry   = ENTRY_W'($urandom);
        it.value   = VAL_W'($urandom);
        it.count   = CNT_W'($urandom);
        it.offset  = SYM_W'($urandom);
        it.symbol  = SYM_W'($urandom);
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: drives at the falling edge, waits for the handshake at the
    // rising edge, then at random drops valid for an idle gap of random length.
    // ------------------------------------------------------------------------
    task automatic send_item(input t_coder_item it);
        int gap;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.action;
        s_axis_tdata  <= {1'b0, it.symbol, it.offset, it.count, it.value, it.entry,
                          it.tbl_idx};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_intervals(it);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic load_header(input int t, input int cnt, input logic [SYM_W-1:0] off);
        t_coder_item it;
        it         = rand_item(ACT_LOAD_HEADER);
        it.tbl_idx = TABLE_W'(t);
        it.count   = CNT_W'(cnt);
        it.offset  = off;
        send_item(it);
    endtask

    task automatic load_bound(input int t, input int e, input int val);
        t_coder_item it;
        it         = rand_item(ACT_LOAD_BOUND);
        it.tbl_idx = TABLE_W'(t);
        it.entry   = ENTRY_W'(e);
        it.value   = VAL_W'(val);
        send_item(it);
    endtask

    task automatic encode(input int t, input logic [SYM_W-1:0] sym);
        t_coder_item it;
        it         = rand_item(ACT_ENCODE);
        it.tbl_idx = TABLE_W'(t);
        it.symbol  = sym;
        send_item(it);
        encodes_sent++;
    endtask

    // Sender stops until every queued interval came out.
    task automatic hold_until_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_intervals.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver back-pressure: random stall bursts while idling is on
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!idle_enable) begin
            m_axis_tready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold    <= ready_hold - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            ready_hold    <= $urandom_range(0, 6);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Checker: every accepted output item against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : interval_check
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_intervals.size() == 0) begin
                report_mismatch("unexpected interval", m_axis_tdata, '0);
            end else begin
                want = pending_intervals.pop_front();
                if (m_axis_tdata[15:0] !== want.start)
                    report_mismatch("interval_start", 40'(m_axis_tdata[15:0]),
                                    40'(want.start));
                if (m_axis_tdata[32:16] !== want.freq)
                    report_mismatch("interval_frequency", 40'(m_axis_tdata[32:16]),
                                    40'(want.freq));
                if (m_axis_tdata[37:33] !== want.scale)
                    report_mismatch("scale_bits", 40'(m_axis_tdata[37:33]),
                                    40'(want.scale));
                if (m_axis_tuser !== want.err)
                    report_mismatch("zero_frequency_error", 40'(m_axis_tuser),
                                    40'(want.err));
                if (m_axis_tlast !== want.last)
                    report_mismatch("last_of_symbol", 40'(m_axis_tlast),
                                    40'(want.last));
            end
        end
    end

    // Watchdog: a hung handshake on both sides ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Tables straight out of reset: count zero, offset zero, so every symbol
    // escapes and the final interval spans the full scale.
    task automatic test_reset_tables();
        encode(0, 16'h0000);
        encode(63, 16'hFFFF);
        encode(0, 16'h7FFF);
        encode(63, 16'h8000);
    endtask

    // Small table with an equal pair and a decreasing pair of boundaries:
    // first index, zero-width and reversed intervals, last index, escapes on
    // both sides, and a spare action code in between.
    task automatic test_cdf_corners();
        t_coder_item it;
        load_header(5, 4, 16'd10);
        load_bound(5, 0, 100);
        load_bound(5, 1, 100);
        load_bound(5, 2, 50);
        load_bound(5, 3, 65535);
        it = rand_item(ACT_UNUSED);
        send_item(it);
        encode(5, 16'd10);
        encode(5, 16'd11);
        encode(5, 16'd12);
        encode(5, 16'd13);
        encode(5, 16'd14);
        encode(5, 16'd9);
    endtask

    // Symbol and offset at opposite extremes: longest escapes, both signs.
    task automatic test_offset_extremes();
        load_header(62, 0, 16'h8000);
        encode(62, 16'h7FFF);
        load_header(61, 0, 16'h7FFF);
        encode(61, 16'h8000);
    endtask

    // Saturating count: only the words at both ends of the 256-entry table
    // are loaded, and only symbols that read those words are encoded.
    task automatic test_full_table();
        logic [SYM_W-1:0] off;
        off = SYM_W'($urandom);
        load_header(40, 9'h1FF, off);
        load_bound(40, 0, 0);
        load_bound(40, 1, $urandom_range(0, 65535));
        load_bound(40, MAX_BOUNDARIES - 2, $urandom_range(0, 65535));
        load_bound(40, MAX_BOUNDARIES - 1, 65535);
        encode(40, off);
        encode(40, off + 16'd1);
        encode(40, off + 16'd255);
        encode(40, off + 16'd256);
        encode(40, off - 16'd1);
    endtask

    // One well-formed session: header, boundaries in order, then encodes.
    // Now and then the boundary load breaks off halfway; encodes then only
    // go out if the table is fully loaded.
    task automatic run_session(input int n_encodes);
        int t;
        int pick;
        int cnt_field;
        int n;
        int n_loads;
        int acc;
        int delta;
        logic [SYM_W-1:0] off;
        t    = $urandom_range(0, NUM_TABLES - 1);
        pick = $urandom_range(0, 19);
        if (pick < 3)
            cnt_field = 0;
        else if (pick < 7)
            cnt_field = $urandom_range(9, 24);
        else
            cnt_field = $urandom_range(1, 8);
        n       = (cnt_field > MAX_BOUNDARIES) ? MAX_BOUNDARIES : cnt_field;
        n_loads = ($urandom_range(0, 9) == 0) ? n / 2 : n;
        off     = SYM_W'($urandom);
        load_header(t, cnt_field, off);
        acc = 0;
        for (int e = 0; e < n_loads; e++) begin
            if ($urandom_range(0, 9) == 0)
                acc = $urandom_range(0, 65535);   // breaks monotony
            else
                acc = acc + $urandom_range(0, 2 * 65536 / (n + 1));
            if (acc > 65535)
                acc = 65535;
            load_bound(t, e, acc);
        end
        if (!table_ready(t))
            return;
        repeat (n_encodes) begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                delta = (n > 0) ? $urandom_range(0, n - 1) : -1;
            else if (pick < 9)
                delta = $urandom_range(0, 1) ? -$urandom_range(1, 4)
                                             : n + $urandom_range(0, 3);
            else
                delta = $urandom;
            encode(t, SYM_W'(int'(off) + delta));
        end
    endtask

    // Stray items between sessions: loads into any table, spare codes,
    // and encodes with random symbols on tables that are safe to read.
    task automatic send_noise();
        t_coder_item it;
        int pick;
        pick = $urandom_range(0, 3);
        if (pick == 0) begin
            it = rand_item(ACT_LOAD_BOUND);
            send_item(it);
        end else if (pick == 1) begin
            it = rand_item(ACT_LOAD_HEADER);
            send_item(it);
        end else if (pick == 2) begin
            it = rand_item(ACT_UNUSED);
            send_item(it);
        end else begin
            it = rand_item(ACT_ENCODE);
            if (table_ready(int'(it.tbl_idx))) begin
                send_item(it);
                encodes_sent++;
            end
        end
    endtask

    task automatic test_random_sessions();
        int goal;
        bit paused;
        goal   = encodes_sent + RANDOM_ENCODES;
        paused = 1'b0;
        while (encodes_sent < goal) begin
            run_session($urandom_range(4, 12));
            repeat ($urandom_range(0, 3)) send_noise();
            // once, midway, let the block run dry before going on
            if (!paused && encodes_sent >= goal - RANDOM_ENCODES / 2) begin
                hold_until_drained();
                paused = 1'b1;
            end
        end
    endtask

    // Back-to-back items and an always-ready receiver.
    task automatic test_steady_stream();
        idle_enable = 1'b0;
        repeat (STEADY_SESSIONS) run_session(10);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_tables();
        test_cdf_corners();
        test_offset_extremes();
        test_full_table();
        test_random_sessions();
        test_steady_stream();

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
